[rtl/pip_pkg.sv]
// Shared types and constants for the point-in-polygon test block.
// No dependencies; used by point_in_polygon_test and pip_checker.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  // Result stream layout: the tdata byte carries the two result flags.
  localparam int OUT_TDATA_W      = 8;
  localparam int OUT_INSIDE_BIT   = 0;
  localparam int OUT_BOUNDARY_BIT = 1;

  // Compare results for one edge A->B against the query point P.
  typedef struct packed {
    logic bx;    // P.x lies between A.x and B.x, inclusive
    logic by;    // P.y lies between A.y and B.y, inclusive
    logic yeq;   // horizontal edge
    logic y1gt;  // A is the upper endpoint
    logic y1p;   // A.y equals P.y
    logic x1le;  // A.x <= P.x
    logic y2gt;  // B is the upper endpoint
    logic y2p;   // B.y equals P.y
    logic x2le;  // B.x <= P.x
  } edge_flags_t;

endpackage

`default_nettype wire

[rtl/point_in_polygon_test.sv]
// Top level of the streaming point-in-polygon test (ray casting).
// Depends on pip_pkg for the edge compare flags and the result layout.
//
// Pipeline: a last vertex reaches its result through three register stages (input,
// products, result). Throughput: one vertex per cycle unless a pending result is stalled;
// the per-edge multiplier stage handles both edges of a vertex in parallel.
// Reset (rst, synchronous, active high) empties the pipeline and arms the block for a
// new polygon; the next transfer is taken as its first vertex.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test #(
  parameter int COORD_BITS = 24
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // Vertex stream.
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, lowest bit up: vertex_x, vertex_y, query_x, query_y, zero pad to bytes.
  input  wire  [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // tlast: last_vertex, closes the polygon.
  input  wire                                  s_axis_tlast,
  // Result stream, one transfer per polygon.
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // tdata, lowest bit up: inside_res, on_boundary, zero pad to a byte.
  output logic [pip_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int W  = COORD_BITS;
  localparam int DW = COORD_BITS + 1;     // width of a coordinate difference
  localparam int PW = 2 * DW;             // width of a product of two differences

  // Unpack the input fields.
  logic signed [W-1:0] in_vx, in_vy, in_qx, in_qy;
  assign in_vx = s_axis_tdata[W-1:0];
  assign in_vy = s_axis_tdata[2*W-1:W];
  assign in_qx = s_axis_tdata[3*W-1:2*W];
  assign in_qy = s_axis_tdata[4*W-1:3*W];

  // Front-end polygon state, updated as each vertex is transferred in.
  logic signed [W-1:0] first_x, first_y, prev_x, prev_y, pt_x, pt_y;
  logic                awaiting_first;

  // Stage A: the two candidate edges of this vertex with the query point.
  // Edge 0 runs from the previous vertex to this one; edge 1 is the closing edge
  // from this vertex back to the first one.
  logic                a_valid, a_first, a_last;
  logic [1:0]          a_ev;
  logic signed [W-1:0] a_x1 [2];
  logic signed [W-1:0] a_y1 [2];
  logic signed [W-1:0] a_x2 [2];
  logic signed [W-1:0] a_y2 [2];
  logic signed [W-1:0] a_px, a_py;

  // Stage B: products and compare flags per edge.
  logic                 b_valid, b_first, b_last;
  logic [1:0]           b_ev;
  logic signed [PW-1:0] b_p [2];
  logic signed [PW-1:0] b_q [2];
  logic signed [PW-1:0] b_r [2];
  logic signed [PW-1:0] b_s [2];
  pip_pkg::edge_flags_t b_flags [2];

  // Running ray-crossing parity and boundary flag of the current polygon.
  logic crossing_parity, boundary_hit;
  logic parity_next, boundary_next;

  // Result register.
  logic out_inside, out_boundary;

  // Flow control: each stage moves when the next one has room. Only a last vertex
  // needs the result register; other vertices leave stage B freely.
  logic s_acc, out_free, b_go, b_free, a_go, a_free;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign b_go     = b_valid && (!b_last || out_free);
  assign b_free   = !b_valid || b_go;
  assign a_go     = a_valid && b_free;
  assign a_free   = !a_valid || a_go;
  assign s_axis_tready = a_free;

  // The first vertex of a polygon brings the query point and becomes the first vertex
  // at once, so the closing edge of a single-vertex polygon runs from it to itself.
  logic signed [W-1:0] px_eff, py_eff, fx_eff, fy_eff;
  assign px_eff = awaiting_first ? in_qx : pt_x;
  assign py_eff = awaiting_first ? in_qy : pt_y;
  assign fx_eff = awaiting_first ? in_vx : first_x;
  assign fy_eff = awaiting_first ? in_vy : first_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
    end else if (s_acc) begin
      awaiting_first <= s_axis_tlast;
    end
    if (s_acc) begin
      if (awaiting_first) begin
        pt_x    <= in_qx;
        pt_y    <= in_qy;
        first_x <= in_vx;
        first_y <= in_vy;
      end
      prev_x <= in_vx;
      prev_y <= in_vy;
    end
  end

  // Stage A register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_acc) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
    if (s_acc) begin
      a_first <= awaiting_first;
      a_last  <= s_axis_tlast;
      a_ev    <= {s_axis_tlast, !awaiting_first};
      a_x1[0] <= prev_x;
      a_y1[0] <= prev_y;
      a_x2[0] <= in_vx;
      a_y2[0] <= in_vy;
      a_x1[1] <= in_vx;
      a_y1[1] <= in_vy;
      a_x2[1] <= fx_eff;
      a_y2[1] <= fy_eff;
      a_px    <= px_eff;
      a_py    <= py_eff;
    end
  end

  // Per-edge arithmetic. Collinearity is tested as
  // (x1-px)(y2-py) - (x2-px)(y1-py) being zero; the row crossing compares
  // (py-y1)(x2-x1) against (px-x1)(y2-y1).
  logic [1:0] hit, tog;

  for (genvar e = 0; e < 2; e++) begin : g_edge
    logic signed [DW-1:0] dx1p, dy2p, dx2p, dy1p, dpy1, dx21, dpx1, dy21;
    logic signed [PW-1:0] p_mul, q_mul, r_mul, s_mul;
    pip_pkg::edge_flags_t flags;
    logic crossing;

    assign dx1p = {a_x1[e][W-1], a_x1[e]} - {a_px[W-1], a_px};
    assign dy2p = {a_y2[e][W-1], a_y2[e]} - {a_py[W-1], a_py};
    assign dx2p = {a_x2[e][W-1], a_x2[e]} - {a_px[W-1], a_px};
    assign dy1p = {a_y1[e][W-1], a_y1[e]} - {a_py[W-1], a_py};
    assign dpy1 = {a_py[W-1], a_py} - {a_y1[e][W-1], a_y1[e]};
    assign dx21 = {a_x2[e][W-1], a_x2[e]} - {a_x1[e][W-1], a_x1[e]};
    assign dpx1 = {a_px[W-1], a_px} - {a_x1[e][W-1], a_x1[e]};
    assign dy21 = {a_y2[e][W-1], a_y2[e]} - {a_y1[e][W-1], a_y1[e]};

    assign p_mul = dx1p * dy2p;
    assign q_mul = dx2p * dy1p;
    assign r_mul = dpy1 * dx21;
    assign s_mul = dpx1 * dy21;

    always_comb begin
      flags.bx   = (a_x1[e] <= a_x2[e]) ? (a_px >= a_x1[e] && a_px <= a_x2[e])
                                        : (a_px >= a_x2[e] && a_px <= a_x1[e]);
      flags.by   = (a_y1[e] <= a_y2[e]) ? (a_py >= a_y1[e] && a_py <= a_y2[e])
                                        : (a_py >= a_y2[e] && a_py <= a_y1[e]);
      flags.yeq  = (a_y1[e] == a_y2[e]);
      flags.y1gt = (a_y1[e] > a_y2[e]);
      flags.y1p  = (a_y1[e] == a_py);
      flags.x1le = (a_x1[e] <= a_px);
      flags.y2gt = (a_y2[e] > a_y1[e]);
      flags.y2p  = (a_y2[e] == a_py);
      flags.x2le = (a_x2[e] <= a_px);
    end

    always_ff @(posedge clk) begin
      if (a_go) begin
        b_p[e]     <= p_mul;
        b_q[e]     <= q_mul;
        b_r[e]     <= r_mul;
        b_s[e]     <= s_mul;
        b_flags[e] <= flags;
      end
    end

    // A point on the closed segment ends the edge; horizontal edges never count.
    // An upper endpoint sitting on the ray counts; otherwise the crossing test
    // decides, with the compare direction set by the edge's y direction.
    assign crossing = b_flags[e].by &&
                      (b_flags[e].y2gt ? (b_r[e] <= b_s[e]) : (b_r[e] >= b_s[e]));
    assign hit[e] = (b_p[e] == b_q[e]) && b_flags[e].bx && b_flags[e].by;
    assign tog[e] = !hit[e] && !b_flags[e].yeq &&
                    ((b_flags[e].y1gt && b_flags[e].y1p && b_flags[e].x1le) ||
                     (b_flags[e].y2gt && b_flags[e].y2p && b_flags[e].x2le) ||
                     crossing);
  end

  // Stage B control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_go) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
    if (a_go) begin
      b_first <= a_first;
      b_last  <= a_last;
      b_ev    <= a_ev;
    end
  end

  // A first vertex starts the polygon's parity and boundary flag over.
  always_comb begin
    parity_next   = (b_first ? 1'b0 : crossing_parity) ^ (b_ev[0] & tog[0])
                    ^ (b_ev[1] & tog[1]);
    boundary_next = (b_first ? 1'b0 : boundary_hit) | (b_ev[0] & hit[0])
                    | (b_ev[1] & hit[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      boundary_hit    <= 1'b0;
    end else if (b_go) begin
      crossing_parity <= parity_next;
      boundary_hit    <= boundary_next;
    end
  end

  // Result register: loaded when a last vertex leaves stage B.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (b_go && b_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (b_go && b_last) begin
      out_inside   <= boundary_next | parity_next;
      out_boundary <= boundary_next;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[pip_pkg::OUT_INSIDE_BIT]   = out_inside;
    m_axis_tdata[pip_pkg::OUT_BOUNDARY_BIT] = out_boundary;
  end

endmodule

`default_nettype wire

[rtl/pip_checker.sv]
// Port-level checks for point_in_polygon_test and the bind that attaches them.
// Depends on pip_pkg for the result layout.
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [pip_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A point on the boundary always counts as inside.
  a_boundary_inside: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[pip_pkg::OUT_BOUNDARY_BIT]
      |-> m_axis_tdata[pip_pkg::OUT_INSIDE_BIT])
    else $error("boundary result not flagged inside");

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/point_in_polygon_test_tb.sv]
// Self-checking testbench for point_in_polygon_test: polygons stream in one vertex per
// transfer, and every verdict is checked against an in-bench ray-casting predictor.
// Depends on the RTL only (pip_pkg and the point_in_polygon_test top level).
`timescale 1ns / 1ps

module point_in_polygon_test_tb;

  localparam int COORD_BITS = 24;
  localparam int IN_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int TOTAL_VERTICES = 1400;
  // The tail of the run has no idling on either side.
  localparam int QUIET_TAIL_START = 1200;
  // Longest legal gap without a transfer is bounded by the idle and stall bursts on
  // both sides plus the three-stage pipeline, so this is many times over.
  localparam int STALL_LIMIT = 2000;
  localparam int N_DIRECTED = 23;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

  // One polygon verdict, as carried by the result stream.
  typedef struct packed {
    logic on_boundary;
    logic inside_res;
  } pip_verdict_t;

  localparam pip_verdict_t VERDICT_OUT = 2'b00;
  localparam pip_verdict_t VERDICT_ON_EDGE = 2'b11;

  // One row of the directed stimulus. When has_verdict is set, the expected verdict is
  // taken from the row itself instead of from the predictor.
  typedef struct {
    coord_t vx;
    coord_t vy;
    coord_t qx;
    coord_t qy;
    bit is_last;
    bit has_verdict;
    pip_verdict_t verdict;
  } vertex_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [pip_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  wire vertex_xfer = s_axis_tvalid && s_axis_tready;
  wire verdict_xfer = m_axis_tvalid && m_axis_tready;

  // Verdicts owed by the block, oldest first.
  pip_verdict_t pending_verdicts[$];
  int mismatch_count = 0;
  bit quiet_tail = 1'b0;

  // Predictor state: the ray origin, the first and previous vertices, crossing parity
  // and the boundary flag of the polygon being walked.
  coord_t ray_x, ray_y;
  coord_t first_x, first_y;
  coord_t prev_x, prev_y;
  bit ray_parity;
  bit edge_touched;
  bit want_first;

  vertex_row_t directed_rows[N_DIRECTED];

  point_in_polygon_test #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit spans(longint v, longint a, longint b);
    return (a <= b) ? (v >= a && v <= b) : (v >= b && v <= a);
  endfunction

  // Applies one edge A->B to the crossing parity and the boundary flag. Coordinate
  // differences are at most 25 bits wide, so every product is exact in 64 bits.
  function automatic void trace_edge(longint x1, longint y1, longint x2, longint y2);
    longint px, py, turn, lean, dy;
    px = ray_x;
    py = ray_y;
    // The point sits on the closed segment: exactly collinear and inside its box.
    turn = (x1 - px) * (y2 - py) - (x2 - px) * (y1 - py);
    if (turn == 0 && spans(px, x1, x2) && spans(py, y1, y2)) begin
      edge_touched = 1'b1;
      return;
    end
    // A horizontal edge never crosses the ray.
    if (y1 == y2) return;
    // The upper endpoint counts once when it lies on the leftward ray.
    if (y1 > y2 && y1 == py && x1 <= px) begin
      ray_parity ^= 1'b1;
      return;
    end
    if (y2 > y1 && y2 == py && x2 <= px) begin
      ray_parity ^= 1'b1;
      return;
    end
    // Otherwise the edge crosses if it meets the ray row at or left of the point; the
    // division is replaced by a signed cross-multiplied compare.
    if (spans(py, y1, y2)) begin
      dy = y2 - y1;
      lean = (py - y1) * (x2 - x1) - (px - x1) * dy;
      if (dy > 0 ? lean <= 0 : lean >= 0) ray_parity ^= 1'b1;
    end
  endfunction

  // Advances the predictor by one accepted vertex. Returns 1 with the verdict when the
  // vertex closes the polygon.
  function automatic bit absorb_vertex(coord_t vx, coord_t vy, coord_t qx, coord_t qy,
                                       bit is_last, output pip_verdict_t verdict);
    verdict = VERDICT_OUT;
    if (want_first) begin
      ray_x = qx;
      ray_y = qy;
      first_x = vx;
      first_y = vy;
      ray_parity = 1'b0;
      edge_touched = 1'b0;
      want_first = 1'b0;
    end else begin
      trace_edge(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (!is_last) return 1'b0;
    // The closing edge back to the first vertex.
    trace_edge(vx, vy, first_x, first_y);
    verdict.inside_res = edge_touched | ray_parity;
    verdict.on_boundary = edge_touched;
    want_first = 1'b1;
    return 1'b1;
  endfunction

  // Presents one vertex and holds it until the block takes it. tvalid is lowered only by
  // an idle burst, a drain or the end of the run, so back-to-back vertices keep it high without a glitch.
  task automatic send_vertex(coord_t vx, coord_t vy, coord_t qx, coord_t qy, bit is_last,
                             bit has_verdict, pip_verdict_t row_verdict);
    pip_verdict_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'({qy, qx, vy, vx});
    s_axis_tlast <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    if (absorb_vertex(vx, vy, qx, qy, is_last, predicted))
      pending_verdicts.push_back(has_verdict ? row_verdict : predicted);
  endtask

  task automatic sender_gap(int odds);
    if (!quiet_tail && odds != 0 && $urandom_range(0, odds - 1) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Holds the sender off until the block has returned every owed verdict.
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Mostly a coarse grid, so that collinear points, shared rows and vertices on the ray
  // are common; the rest is small noise, full-range values and the extremes.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return coord_t'((int'($urandom_range(0, 8)) - 4) * 256);
      6, 7: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      8: return coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return COORD_MIN + 1;
          default: return COORD_MAX - 1;
        endcase
      end
    endcase
  endfunction

  // Result checking. Samples at the edge, so it sees the values that the edge captures.
  always @(posedge clk) begin
    pip_verdict_t got, owed;
    if (!rst && verdict_xfer) begin
      got.inside_res = m_axis_tdata[pip_pkg::OUT_INSIDE_BIT];
      got.on_boundary = m_axis_tdata[pip_pkg::OUT_BOUNDARY_BIT];
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: verdict with none owed: inside=%b boundary=%b",
                   $realtime, got.inside_res, got.on_boundary);
      end else begin
        owed = pending_verdicts.pop_front();
        if (got.inside_res !== owed.inside_res || got.on_boundary !== owed.on_boundary) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: verdict mismatch: expected inside=%b boundary=%b, got %b %b",
                     $realtime, owed.inside_res, owed.on_boundary,
                     got.inside_res, got.on_boundary);
        end
      end
    end
  end

  // Receiver: random stall bursts, with calm stretches between them.
  initial begin
    int calm_left;
    calm_left = 0;
    @(posedge clk);
    forever begin
      if (calm_left == 0 && $urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 120);
      if (!quiet_tail && calm_left == 0 && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left != 0) calm_left--;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing has moved on either stream for too long.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (vertex_xfer || verdict_xfer) stalled = 0;
      else stalled++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    coord_t poly_x[8], poly_y[8];
    coord_t qx, qy;
    int sides, pick, gap_odds, polygons, sent;

    ray_x = '0;
    ray_y = '0;
    first_x = '0;
    first_y = '0;
    prev_x = '0;
    prev_y = '0;
    ray_parity = 1'b0;
    edge_touched = 1'b0;
    want_first = 1'b1;

    // Verdicts are written as {on_boundary, inside_res}.
    directed_rows = '{
      // One-vertex polygon with the point on its vertex, then away from it.
      '{100, 200, 100, 200, 1'b1, 1'b1, VERDICT_ON_EDGE},
      '{0, 0, 5, 5, 1'b1, 1'b1, VERDICT_OUT},
      // Full-range square around the origin; query fields after the first are junk.
      '{COORD_MIN, COORD_MIN, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 1'b0, VERDICT_OUT},
      '{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0, VERDICT_OUT},
      '{COORD_MIN, COORD_MAX, 0, 0, 1'b1, 1'b0, VERDICT_OUT},
      // Triangle whose first corner is the point, at the negative extreme.
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0, VERDICT_OUT},
      '{COORD_MAX, COORD_MIN, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{0, COORD_MAX, 0, 0, 1'b1, 1'b1, VERDICT_ON_EDGE},
      // Two-vertex polygon with the point in the middle of the segment.
      '{-256, -256, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{256, 256, 0, 0, 1'b1, 1'b1, VERDICT_ON_EDGE},
      // Square whose bottom edge lies on the ray row, point to its left.
      '{0, 0, -100, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{256, 0, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{256, 256, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{0, 256, 0, 0, 1'b1, 1'b0, VERDICT_OUT},
      // Triangle with the ray passing through its right corner.
      '{0, 0, 512, 256, 1'b0, 1'b0, VERDICT_OUT},
      '{256, 256, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{0, 512, 0, 0, 1'b1, 1'b0, VERDICT_OUT},
      // Square with the point far to its right at the largest x.
      '{-512, -512, COORD_MAX, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{512, -512, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{512, 512, 0, 0, 1'b0, 1'b0, VERDICT_OUT},
      '{-512, 512, 0, 0, 1'b1, 1'b0, VERDICT_OUT},
      // Point at the largest y on a one-vertex polygon elsewhere.
      '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1, VERDICT_OUT}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      sender_gap(6);
      send_vertex(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].qx,
                  directed_rows[i].qy, directed_rows[i].is_last,
                  directed_rows[i].has_verdict, directed_rows[i].verdict);
    end
    sent = N_DIRECTED;
    drain_verdicts();

    // Random polygons. Every polygon is well formed (closed by a last vertex); the
    // query point is often a vertex or an edge midpoint so the boundary path is hit.
    polygons = 0;
    while (sent < TOTAL_VERTICES) begin
      case ($urandom_range(0, 9))
        0: sides = 1;
        1: sides = 2;
        default: sides = $urandom_range(3, 8);
      endcase
      for (int k = 0; k < sides; k++) begin
        poly_x[k] = pick_coord();
        poly_y[k] = pick_coord();
      end
      pick = $urandom_range(0, sides - 1);
      case ($urandom_range(0, 7))
        0, 1: begin
          qx = poly_x[pick];
          qy = poly_y[pick];
        end
        2: begin
          qx = coord_t'((longint'(poly_x[pick]) + longint'(poly_x[(pick + 1) % sides])) >>> 1);
          qy = coord_t'((longint'(poly_y[pick]) + longint'(poly_y[(pick + 1) % sides])) >>> 1);
        end
        default: begin
          qx = pick_coord();
          qy = pick_coord();
        end
      endcase

      gap_odds = $urandom_range(0, 3) * 4;
      quiet_tail = (sent >= QUIET_TAIL_START);
      for (int k = 0; k < sides; k++) begin
        sender_gap(gap_odds);
        // Query fields of later vertices carry noise that the block must ignore.
        send_vertex(poly_x[k], poly_y[k], (k == 0) ? qx : coord_t'($urandom),
                    (k == 0) ? qy : coord_t'($urandom), k == sides - 1, 1'b0, VERDICT_OUT);
        sent++;
      end
      polygons++;
      if (polygons == 150) drain_verdicts();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    // Let any stray result surface past the three-stage pipeline.
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pip_pkg.sv
rtl/point_in_polygon_test.sv
rtl/pip_checker.sv
dv/point_in_polygon_test_tb.sv
